@@ hdl/vertex_perspective_projection_top_macros.svh @@
// assertion macros for the vertex projection block
`ifndef VERTEX_PERSPECTIVE_PROJECTION_TOP_MACROS_SVH
`define VERTEX_PERSPECTIVE_PROJECTION_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define VPP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vpp assertion failed");

// next-cycle implication, checked out of reset
`define VPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vpp assertion failed");

`endif

@@ hdl/vpp_pkg.sv @@
// shared types, constants and helpers for the vertex projection block
`timescale 1ns / 1ps
`default_nettype none

package vpp_pkg;

    localparam int CLIP_W      = 50;
    localparam int DIV_Q_W     = 31;
    localparam int DIV_STAGES  = 32;
    localparam int SQRT_STAGES = 32;
    localparam int DIM_W       = 13;
    localparam int PIPE_DEPTH  = 3 + DIV_STAGES + 3;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd600;

    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        ACT_LOAD_MAT  = 2'd0,
        ACT_LOAD_VIEW = 2'd1,
        ACT_PROJECT   = 2'd2
    } action_t;

    typedef logic signed [CLIP_W-1:0] clip_t;
    typedef logic [CLIP_W-1:0]        mag_t;

    typedef struct packed {
        logic               mat_we;
        logic [3:0]         slot;
        logic signed [31:0] value;
    } load_t;

    typedef struct packed {
        logic       vis;
        logic [2:0] neg;
        logic       dsat;
    } tag_t;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -48'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/vertex_perspective_projection_top.sv @@
// top level: vertex projection to pixels with distance to viewer
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tuser action, tdata slot..point_z
//  m_axis   out  m_axis_tvalid/tready       tuser visible, tdata pixels..range
//  cfg      in   cfg_we                     cfg_index, cfg_wdata
//
//  one beat per cycle in and out unless the output holds; a point passes
//  through the 32-stage divider and the 32-stage square root pipelines
//  load beats update the matrix or viewer at accept and give no result
//  the whole pipeline advances together; it holds while the output waits
//  reset is synchronous, active low, and clears valids, matrix and viewer
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_perspective_projection_top_macros.svh"

module vertex_perspective_projection_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,  // slot, load_value, point_x, point_y, point_z
    input  wire logic [1:0]   s_axis_tuser,  // action
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [95:0]       m_axis_tdata,  // pixel_x, pixel_y, ndc_depth, range_to_viewer
    output logic              m_axis_tuser,  // visible
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [12:0]  cfg_wdata
);

    localparam int ND = vpp_pkg::DIV_STAGES;
    localparam int NP = vpp_pkg::PIPE_DEPTH;

    logic                    adv;
    logic                    s_fire;
    vpp_pkg::action_t        act;
    vpp_pkg::load_t          load_s;
    logic [3:0]              slot;
    logic signed [31:0]      load_value;
    logic signed [31:0]      pt [3];

    logic [12:0]             scr_w_reg;
    logic [12:0]             scr_h_reg;
    logic signed [31:0]      view_reg [3];
    logic                    vld_reg [NP];

    logic signed [32:0]      diff_reg [3];
    logic [32:0]             dmag [3];
    logic [63:0]             sq_reg [3];
    logic                    dsat2_reg;
    logic [65:0]             sqsum;

    vpp_pkg::clip_t          clip [4];
    vpp_pkg::mag_t           cmag [3];
    vpp_pkg::mag_t           mag3_reg [3];
    vpp_pkg::mag_t           w3_reg;
    vpp_pkg::tag_t           tag3_reg;
    logic [63:0]             dsum_reg;
    vpp_pkg::tag_t           tag_reg [ND];

    logic [vpp_pkg::DIV_Q_W-1:0] quo [3];
    logic                    ovf [3];
    logic [31:0]             root;

    logic signed [31:0]      nd_reg [3];
    logic [31:0]             rng36_reg;
    logic                    vis36_reg;
    logic signed [46:0]      mx_reg;
    logic signed [46:0]      my_reg;
    logic signed [31:0]      nz37_reg;
    logic [31:0]             rng37_reg;
    logic                    vis37_reg;
    logic signed [47:0]      px_full;
    logic signed [47:0]      py_full;

    logic signed [15:0]      px_reg;
    logic signed [15:0]      py_reg;
    logic signed [31:0]      nz_reg;
    logic [31:0]             rng_reg;
    logic                    vis_reg;

    assign adv           = !vld_reg[NP-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign act           = vpp_pkg::action_t'(s_axis_tuser);
    assign slot          = s_axis_tdata[3:0];
    assign load_value    = s_axis_tdata[35:4];
    assign pt[0]         = s_axis_tdata[67:36];
    assign pt[1]         = s_axis_tdata[99:68];
    assign pt[2]         = s_axis_tdata[131:100];

    assign load_s.mat_we = s_fire && (act == vpp_pkg::ACT_LOAD_MAT);
    assign load_s.slot   = slot;
    assign load_s.value  = load_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg <= vpp_pkg::WIDTH_RESET;
            scr_h_reg <= vpp_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == vpp_pkg::CFG_SCREEN_WIDTH) scr_w_reg <= cfg_wdata;
            if (cfg_index == vpp_pkg::CFG_SCREEN_HEIGHT) scr_h_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) view_reg[i] <= '0;
        end else if (s_fire && (act == vpp_pkg::ACT_LOAD_VIEW)) begin
            for (int i = 0; i < 3; i++) begin
                if (slot == 4'(i)) view_reg[i] <= load_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NP; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_fire && (act == vpp_pkg::ACT_PROJECT);
            for (int i = 1; i < NP; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    vpp_xform u_xform (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .load    (load_s),
        .point_x (pt[0]),
        .point_y (pt[1]),
        .point_z (pt[2]),
        .clip_o  (clip)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dmag[i] = diff_reg[i][32] ? 33'(-diff_reg[i]) : 33'(diff_reg[i]);
            cmag[i] = clip[i][vpp_pkg::CLIP_W-1] ? vpp_pkg::mag_t'(-clip[i])
                                                 : vpp_pkg::mag_t'(clip[i]);
        end
        sqsum = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
    end

    // front end: differences, squares, magnitudes
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                diff_reg[i] <= 33'(pt[i]) - 33'(view_reg[i]);
                sq_reg[i]   <= dmag[i][31:0] * dmag[i][31:0];
                mag3_reg[i] <= cmag[i];
                tag3_reg.neg[i] <= clip[i][vpp_pkg::CLIP_W-1];
            end
            dsat2_reg     <= dmag[0][32] || dmag[1][32] || dmag[2][32];
            tag3_reg.dsat <= dsat2_reg || (sqsum[65:64] != 2'b0);
            tag3_reg.vis  <= !clip[3][vpp_pkg::CLIP_W-1] && (clip[3] != '0);
            w3_reg        <= vpp_pkg::mag_t'(clip[3]);
            dsum_reg      <= sqsum[63:0];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        vpp_div u_div (
            .aclk (aclk),
            .adv  (adv),
            .num  (mag3_reg[i]),
            .den  (w3_reg),
            .quo  (quo[i]),
            .ovf  (ovf[i])
        );
    end

    vpp_sqrt u_sqrt (
        .aclk     (aclk),
        .adv      (adv),
        .radicand (dsum_reg),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0] <= tag3_reg;
            for (int i = 1; i < ND; i++) tag_reg[i] <= tag_reg[i-1];
        end
    end

    // back end: sign and saturate, viewport multiply, offset and clamp
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                if (tag_reg[ND-1].neg[i]) begin
                    nd_reg[i] <= ovf[i] ? 32'sh8000_0000 : -$signed({1'b0, quo[i]});
                end else begin
                    nd_reg[i] <= ovf[i] ? 32'sh7FFF_FFFF : $signed({1'b0, quo[i]});
                end
            end
            rng36_reg <= tag_reg[ND-1].dsat ? 32'hFFFF_FFFF : root;
            vis36_reg <= tag_reg[ND-1].vis;

            mx_reg    <= 47'(nd_reg[0]) * 47'($signed({1'b0, scr_w_reg}));
            my_reg    <= 47'(nd_reg[1]) * 47'($signed({1'b0, scr_h_reg}));
            nz37_reg  <= nd_reg[2];
            rng37_reg <= rng36_reg;
            vis37_reg <= vis36_reg;

            px_reg  <= vis37_reg ? vpp_pkg::sat16(px_full >>> 17) : '0;
            py_reg  <= vis37_reg ? vpp_pkg::sat16(py_full >>> 17) : '0;
            nz_reg  <= vis37_reg ? nz37_reg : '0;
            rng_reg <= rng37_reg;
            vis_reg <= vis37_reg;
        end
    end

    assign px_full = 48'(mx_reg) + 48'($signed({1'b0, scr_w_reg, 16'b0}));
    assign py_full = 48'($signed({1'b0, scr_h_reg, 16'b0})) - 48'(my_reg);

    assign m_axis_tvalid = vld_reg[NP-1];
    assign m_axis_tdata  = {rng_reg, nz_reg, py_reg, px_reg};
    assign m_axis_tuser  = vis_reg;

    `VPP_ASSERT_NOW(a_hidden_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[63:0] == 64'b0)
    `VPP_ASSERT_NEXT(a_proj_enters, s_fire && (act == vpp_pkg::ACT_PROJECT), vld_reg[0])
    `VPP_ASSERT_NEXT(a_load_silent, s_fire && (act != vpp_pkg::ACT_PROJECT), !vld_reg[0])

endmodule

`default_nettype wire

@@ hdl/vpp_xform.sv @@
// matrix store and matrix-vector product, products then sums
`timescale 1ns / 1ps
`default_nettype none

module vpp_xform (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               adv,
    input  wire vpp_pkg::load_t     load,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    output vpp_pkg::clip_t          clip_o [4]
);

    logic signed [31:0] mat_reg   [16];
    logic signed [63:0] prod_reg  [12];
    logic signed [31:0] trans_reg [4];
    vpp_pkg::clip_t     clip_reg  [4];
    logic signed [31:0] pt        [3];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
        end else if (load.mat_we) begin
            mat_reg[load.slot] <= load.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 4; r++) begin
                    prod_reg[c*4+r] <= 64'(mat_reg[c*4+r]) * 64'(pt[c]);
                end
            end
            for (int r = 0; r < 4; r++) begin
                trans_reg[r] <= mat_reg[12+r];
                clip_reg[r]  <= vpp_pkg::CLIP_W'(prod_reg[r] >>> 16)
                              + vpp_pkg::CLIP_W'(prod_reg[4+r] >>> 16)
                              + vpp_pkg::CLIP_W'(prod_reg[8+r] >>> 16)
                              + vpp_pkg::CLIP_W'(trans_reg[r]);
            end
        end
    end

    assign clip_o = clip_reg;

endmodule

`default_nettype wire

@@ hdl/vpp_div.sv @@
// pipelined restoring divider, one quotient bit per stage after stage zero
`timescale 1ns / 1ps
`default_nettype none

module vpp_div (
    input  wire logic                          aclk,
    input  wire logic                          adv,
    input  wire vpp_pkg::mag_t                 num,
    input  wire vpp_pkg::mag_t                 den,
    output logic [vpp_pkg::DIV_Q_W-1:0]        quo,
    output logic                               ovf
);

    localparam int RW = vpp_pkg::CLIP_W + 1;
    localparam int QW = vpp_pkg::DIV_Q_W;
    localparam int NS = vpp_pkg::DIV_STAGES;

    logic [RW-1:0]      r_reg   [NS];
    logic [QW-1:0]      q_reg   [NS];
    vpp_pkg::mag_t      d_reg   [NS];
    logic [QW-1:0]      lo_reg  [NS];
    logic               ovf_reg [NS];

    // stage zero: overflow check and remainder seed
    always_ff @(posedge aclk) begin
        if (adv) begin
            ovf_reg[0] <= {15'b0, num} >= {den, 15'b0};
            r_reg[0]   <= {16'b0, num[vpp_pkg::CLIP_W-1:15]};
            lo_reg[0]  <= {num[14:0], 16'b0};
            q_reg[0]   <= '0;
            d_reg[0]   <= den;
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_step
        localparam int K = QW - s;
        logic [RW-1:0] rs;
        logic          ge;
        logic [QW-1:0] qn;

        always_comb begin
            rs    = {r_reg[s-1][RW-2:0], lo_reg[s-1][K]};
            ge    = rs >= {1'b0, d_reg[s-1]};
            qn    = q_reg[s-1];
            qn[K] = ge;
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                r_reg[s]   <= ge ? rs - {1'b0, d_reg[s-1]} : rs;
                q_reg[s]   <= qn;
                d_reg[s]   <= d_reg[s-1];
                lo_reg[s]  <= lo_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    assign quo = q_reg[NS-1];
    assign ovf = ovf_reg[NS-1];

endmodule

`default_nettype wire

@@ hdl/vpp_sqrt.sv @@
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none

module vpp_sqrt (
    input  wire logic        aclk,
    input  wire logic        adv,
    input  wire logic [63:0] radicand,
    output logic [31:0]      root
);

    localparam int NS = vpp_pkg::SQRT_STAGES;

    logic [35:0] rem_reg  [NS];
    logic [31:0] root_reg [NS];
    logic [63:0] v_reg    [NS];

    for (genvar s = 0; s < NS; s++) begin : g_step
        localparam int I = NS - 1 - s;
        logic [35:0] rem_p;
        logic [31:0] root_p;
        logic [63:0] v_p;
        logic [35:0] rs;
        logic [35:0] trial;
        logic        ge;

        always_comb begin
            if (s == 0) begin
                rem_p  = '0;
                root_p = '0;
                v_p    = radicand;
            end else begin
                rem_p  = rem_reg[(s == 0) ? 0 : s-1];
                root_p = root_reg[(s == 0) ? 0 : s-1];
                v_p    = v_reg[(s == 0) ? 0 : s-1];
            end
            rs    = {rem_p[33:0], v_p[2*I+1], v_p[2*I]};
            trial = {2'b0, root_p, 2'b01};
            ge    = rs >= trial;
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[s]  <= ge ? rs - trial : rs;
                root_reg[s] <= {root_p[30:0], ge};
                v_reg[s]    <= v_p;
            end
        end
    end

    assign root = root_reg[NS-1];

endmodule

`default_nettype wire
